### sv/sitrt_pkg.sv
package sitrt_pkg;

  // Alphabet limits and the width of a symbol index.
  localparam int unsigned MAX_SYMBOLS = 32;
  localparam int unsigned SYM_IDX_W   = $clog2(MAX_SYMBOLS);

  // Input word width and the digit stack it needs (radix two is the longest).
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned MAX_DIGITS  = VALUE_W;
  localparam int unsigned DIG_PTR_W   = $clog2(MAX_DIGITS);
  localparam int unsigned DIG_CNT_W   = $clog2(MAX_DIGITS + 1);

  // Quotient bits resolved per cycle by the shared divide step.
  localparam int unsigned STEP_BITS       = 4;
  localparam int unsigned STEPS_PER_DIGIT = VALUE_W / STEP_BITS;
  localparam int unsigned STEP_CNT_W      = $clog2(STEPS_PER_DIGIT);

  // Base size register and remainder width.
  localparam int unsigned BASE_W = 6;

  // Character codes that the alphabet may not use.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SYM_0_7   = 3'd0,
    REG_SYM_8_15  = 3'd1,
    REG_SYM_16_23 = 3'd2,
    REG_SYM_24_31 = 3'd3,
    REG_BASE_SIZE = 3'd4
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } state_e;

  typedef logic [4*64-1:0] sym_flat_t;

  // Picks one byte-wide symbol out of the flattened alphabet.
  function automatic logic [7:0] sym_at(input sym_flat_t flat,
                                        input logic [SYM_IDX_W-1:0] idx);
    sym_at = flat[idx*8 +: 8];
  endfunction

endpackage

### sv/signed_integer_to_radix_text_top.sv
// Channel     Ports                                   Direction  Handshake
// ----------  --------------------------------------  ---------  ------------------------
// command     start, busy, value_i[31:0]              in         start & !busy
// result      out_strobe_o, symbol_o[7:0], last_o     out        one-cycle strobe
// config      cfg_we_i, cfg_idx_i[2:0], cfg_data_i    in         cfg_we_i, no wait
//
// An item first runs an alphabet check, one symbol per cycle, over the first base_size symbols.
// Each digit is then resolved in the shared compare-subtract unit, 4 quotient bits
// a cycle, until the quotient is zero, and the characters are sent after that.
// The busy flag drops in the cycle that presents the last character, so the next word
// can be taken then. Reset clears the sequencer and all configuration registers to zero.
// Characters come out one per cycle and the receiver cannot hold them off.
module signed_integer_to_radix_text_top
  import sitrt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  value_i,
  output logic                out_strobe_o,
  output logic [7:0]          symbol_o,
  output logic                last_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i
);

  state_e                  state_q, state_d;
  logic [3:0][63:0]        sym_q;
  logic [BASE_W-1:0]       base_q;
  logic                    neg_q, neg_d;
  logic [VALUE_W-1:0]      mag_q, mag_d;
  logic [BASE_W-1:0]       rem_q, rem_d;
  logic [STEP_CNT_W-1:0]   step_q, step_d;
  logic [SYM_IDX_W-1:0]    chk_q, chk_d;
  logic [DIG_CNT_W-1:0]    nd_q, nd_d;
  logic [DIG_PTR_W-1:0]    ptr_q, ptr_d;
  logic [SYM_IDX_W-1:0]    dig_q [MAX_DIGITS];
  logic                    push;
  logic                    strobe_q, strobe_d;
  logic [7:0]              symbol_q, symbol_d;
  logic                    last_q, last_d;

  sym_flat_t               sym_flat;
  logic [7:0]              chk_sym;
  logic                    size_bad;
  logic                    sym_bad;
  logic [VALUE_W-1:0]      quo_step;
  logic [BASE_W-1:0]       rem_step;

  assign sym_flat = sym_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q  <= '0;
      base_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SYM_0_7:   sym_q[0] <= cfg_data_i;
        REG_SYM_8_15:  sym_q[1] <= cfg_data_i;
        REG_SYM_16_23: sym_q[2] <= cfg_data_i;
        REG_SYM_24_31: sym_q[3] <= cfg_data_i;
        REG_BASE_SIZE: base_q   <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Alphabet check for the symbol under test: forbidden sign characters, or a
  // repeat further up within the base size. The lanes compare in parallel.
  assign size_bad = (base_q < BASE_W'(2)) || (base_q > BASE_W'(MAX_SYMBOLS));
  assign chk_sym  = sym_at(sym_flat, chk_q);

  always_comb begin
    sym_bad = (chk_sym == CH_PLUS) || (chk_sym == CH_MINUS);
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      if ((BASE_W'(j) > BASE_W'(chk_q)) && (BASE_W'(j) < base_q) &&
          (sym_at(sym_flat, SYM_IDX_W'(j)) == chk_sym)) begin
        sym_bad = 1'b1;
      end
    end
  end

  // Shared divide unit: restoring division by the radix, a few quotient bits a
  // cycle. The quotient shifts into the magnitude word in place.
  always_comb begin
    logic [BASE_W:0]    trial;
    logic [BASE_W-1:0]  r;
    logic [VALUE_W-1:0] q;
    r = rem_q;
    q = mag_q;
    for (int s = 0; s < STEP_BITS; s++) begin
      trial = {r, q[VALUE_W-1]};
      q     = {q[VALUE_W-2:0], 1'b0};
      if (trial >= {1'b0, base_q}) begin
        trial = trial - {1'b0, base_q};
        q[0]  = 1'b1;
      end
      r = trial[BASE_W-1:0];
    end
    quo_step = q;
    rem_step = r;
  end

  // Sequencer: check the alphabet, peel off digits, then send the text.
  always_comb begin
    state_d  = state_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    rem_d    = rem_q;
    step_d   = step_q;
    chk_d    = chk_q;
    nd_d     = nd_q;
    ptr_d    = ptr_q;
    push     = 1'b0;
    strobe_d = 1'b0;
    symbol_d = symbol_q;
    last_d   = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          neg_d   = value_i[VALUE_W-1];
          mag_d   = value_i[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value_i))
                                       : VALUE_W'(value_i);
          rem_d   = '0;
          step_d  = '0;
          chk_d   = '0;
          nd_d    = '0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (size_bad || sym_bad) begin
          state_d = ST_IDLE;
        end else if ({1'b0, chk_q} == base_q - BASE_W'(1)) begin
          state_d = ST_DIVIDE;
        end else begin
          chk_d = chk_q + SYM_IDX_W'(1);
        end
      end
      ST_DIVIDE: begin
        mag_d  = quo_step;
        rem_d  = rem_step;
        step_d = step_q + STEP_CNT_W'(1);
        // A digit is complete: push it and stop once the quotient is zero.
        // Zero itself still yields one digit.
        if (step_q == STEP_CNT_W'(STEPS_PER_DIGIT - 1)) begin
          push  = 1'b1;
          rem_d = '0;
          nd_d  = nd_q + DIG_CNT_W'(1);
          ptr_d = nd_q[DIG_PTR_W-1:0];
          if (quo_step == '0) begin
            state_d = neg_q ? ST_SIGN : ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        strobe_d = 1'b1;
        symbol_d = CH_MINUS;
        last_d   = 1'b0;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        strobe_d = 1'b1;
        symbol_d = sym_at(sym_flat, dig_q[ptr_q]);
        last_d   = (ptr_q == '0);
        if (ptr_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q - DIG_PTR_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      step_q   <= '0;
      chk_q    <= '0;
      nd_q     <= '0;
      ptr_q    <= '0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      step_q   <= step_d;
      chk_q    <= chk_d;
      nd_q     <= nd_d;
      ptr_q    <= ptr_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    rem_q    <= rem_d;
    symbol_q <= symbol_d;
    last_q   <= last_d;
  end

  // Digit stack, least significant digit pushed first.
  always_ff @(posedge clk_i) begin
    if (push) begin
      dig_q[nd_q[DIG_PTR_W-1:0]] <= rem_step[SYM_IDX_W-1:0];
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign out_strobe_o = strobe_q;
  assign symbol_o     = symbol_q;
  assign last_o       = last_q;

`ifndef SYNTHESIS
  // An accepted command always starts the alphabet check.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> state_q == ST_CHECK)
    else $error("accepted command did not start the check");

  // The running remainder never reaches the radix.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIVIDE |-> rem_q < base_q)
    else $error("remainder out of range");

  // The last character of a number is never directly followed by another.
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && last_o |=> !out_strobe_o)
    else $error("character right after the last one");

  // The digit stack never overflows.
  a_stack_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nd_q <= DIG_CNT_W'(MAX_DIGITS))
    else $error("digit stack overflow");

  // Characters leave only while the sequencer is emitting or has just finished.
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(state_q) == ST_SIGN || $past(state_q) == ST_EMIT)
    else $error("character strobe outside the emit phase");
`endif

endmodule
